>>> sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] FAIL_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic read_pending;
    } t_stat;

endpackage

>>> sv/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_if
// request and response channels of the circular double-ended queue
// ----------------------------------------------------------------------------
interface cdq_in_if import cdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_op                      op;
    logic signed [DATA_W-1:0] data;

    modport source (output valid, output op, output data, input ready);
    modport sink   (input valid, input op, input data, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; #(
    parameter int CNT_W = 5
) ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    t_status                  status;
    logic [CNT_W-1:0]         count;

    modport source (output valid, output value, output status, output count, input ready);
    modport sink   (input valid, input value, input status, input count, output ready);
endinterface

>>> sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// pointers, occupancy, store and result registers of the deque
// ----------------------------------------------------------------------------
module cdq_datapath import cdq_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_data,
    output logic signed [DATA_W-1:0] o_value,
    output t_status                  o_status,
    output logic [CNT_W-1:0]         o_count
);

    localparam logic [AW-1:0]    LAST = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_value, n_value;
    t_status                  r_status, n_status;

    logic          we, re, read_pending;
    logic [AW-1:0] waddr, raddr;
    logic [DATA_W-1:0] rdata;

    logic is_full, no_words;
    assign is_full  = (r_count == FULL);
    assign no_words = (r_count == '0);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_value      = r_value;
        n_status     = r_status;
        we           = 1'b0;
        re           = 1'b0;
        read_pending = 1'b0;
        waddr        = '0;
        raddr        = r_head;
        case (i_op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                n_value = '0;
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    we       = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    if (no_words) begin
                        n_head = '0;
                        n_tail = '0;
                        waddr  = '0;
                    end else if (i_op == OP_PUSH_FRONT) begin
                        n_head = (r_head == '0) ? LAST : r_head - AW'(1);
                        waddr  = n_head;
                    end else begin
                        n_tail = (r_tail == LAST) ? '0 : r_tail + AW'(1);
                        waddr  = n_tail;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (no_words) begin
                    n_status = ST_EMPTY;
                    n_value  = FAIL_VALUE;
                end else begin
                    n_status     = ST_OK;
                    re           = 1'b1;
                    read_pending = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    raddr        = (i_op == OP_POP_FRONT) ? r_head : r_tail;
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end else if (i_op == OP_POP_FRONT) begin
                        n_head = (r_head == LAST) ? '0 : r_head + AW'(1);
                    end else begin
                        n_tail = (r_tail == '0) ? LAST : r_tail - AW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.accept),
        .i_waddr (waddr),
        .i_wdata (i_data),
        .i_re    (re && i_cmd.accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value  <= n_value;
            r_status <= n_status;
        end else if (i_cmd.load) begin
            r_value  <= $signed(rdata);
        end
    end

    assign o_stat.read_pending = read_pending;
    assign o_value             = r_value;
    assign o_status            = r_status;
    assign o_count             = r_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("occupancy beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && read_pending && r_count == CNT_W'(1)
        |=> r_head == '0 && r_tail == '0)
        else $error("pointers not cleared after last pop");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && is_full && (i_op == OP_PUSH_FRONT || i_op == OP_PUSH_REAR)
        |=> r_count == FULL)
        else $error("refused push changed occupancy");
`endif

endmodule

>>> sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// handshake sequencer of the deque
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;

    assign accept = i_in_valid && r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        if (i_stat.read_pending) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state     <= S_DONE;
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_LOAD: begin
                    r_state     <= S_DONE;
                    r_out_valid <= 1'b1;
                end
                S_DONE: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_ready  <= 1'b1;
                end
            endcase
        end
    end

    assign o_cmd.accept = accept;
    assign o_cmd.load   = (r_state == S_LOAD);
    assign o_in_ready   = r_in_ready;
    assign o_out_valid  = r_out_valid;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("request and response open together");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_stat.read_pending |=> r_state == S_LOAD && !r_out_valid)
        else $error("pop did not wait for store data");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");

    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept) || $past(r_state == S_LOAD))
        else $error("response without transaction");
`endif

endmodule

>>> sv/circular_double_ended_queue_unit.sv
// response: a push or a refused pop gives its response in the cycle after acceptance;
//   an accepted pop gives it after the registered store read and the response register load
// flow: one transaction at a time; a new request is accepted only after the response
//   is taken
// reset: synchronous active-low i_rst_n clears pointers and occupancy; store is not cleared
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// fixed-depth double-ended queue of signed words in a circular store
// ----------------------------------------------------------------------------
module circular_double_ended_queue_unit import cdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdq_in_if.sink     i_req,   // operation and push word
    cdq_out_if.source  o_rsp    // popped word, status, occupancy after the step
);

    // the response channel interface must be built with CNT_W = $clog2(DEPTH + 1)

    t_cmd  cmd;    // accept strobe and store-data load
    t_stat stat;   // accepted transaction is a pop that reads the store

    // controller: idle -> (load) -> done, one transaction in flight
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: head/tail pointers with wrap, occupancy, store ram and
    // the response register that holds while the response waits
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_op     (i_req.op),
        .i_data   (i_req.data),
        .o_value  (o_rsp.value),
        .o_status (o_rsp.status),
        .o_count  (o_rsp.count)
    );

endmodule
